// File: src/m2bl_pkg.sv
package m2bl_pkg;

    localparam int MAX_X_POINTS  = 16;
    localparam int MAX_Y_POINTS  = 16;
    localparam int DATA_WIDTH    = 16;
    localparam int FRACTION_BITS = 16;

    localparam int X_IDX_W  = $clog2(MAX_X_POINTS);
    localparam int Y_IDX_W  = $clog2(MAX_Y_POINTS);
    localparam int CNT_W    = 5;
    localparam int GRID_D   = MAX_X_POINTS * MAX_Y_POINTS;
    localparam int GRID_AW  = $clog2(GRID_D);
    localparam int FRAC_W   = FRACTION_BITS + 1;
    localparam int ACC_W    = DATA_WIDTH + FRAC_W + 1;

    typedef enum logic [1:0] {
        CMD_WR_X   = 2'd0,
        CMD_WR_Y   = 2'd1,
        CMD_WR_MAP = 2'd2,
        CMD_LOOKUP = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_WIDTH = 2'd1,
        ST_BAD_INDEX  = 2'd2
    } status_t;

    localparam logic CFG_X_POINTS = 1'b0;
    localparam logic CFG_Y_POINTS = 1'b1;

    typedef struct packed {
        cmd_t                         cmd;
        logic                         idx_ok;
        logic [3:0]                   row;
        logic [3:0]                   col;
        logic signed [DATA_WIDTH-1:0] wv;
        logic signed [15:0]           qx;
        logic signed [15:0]           qy;
    } item_t;

    function automatic logic [CNT_W-1:0] used_count(input logic [CNT_W-1:0] r,
                                                    input logic [CNT_W-1:0] maxv);
        logic [CNT_W-1:0] v;
        begin
            v = r;
            if (r < CNT_W'(2))
                v = CNT_W'(2);
            else if (r > maxv)
                v = maxv;
            return v;
        end
    endfunction

endpackage

// File: src/m2bl_ram.sv
module m2bl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: src/m2bl_front.sv
module m2bl_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  m2bl_pkg::item_t           in_item,
    input  logic [m2bl_pkg::CNT_W-1:0] nx,
    input  logic [m2bl_pkg::CNT_W-1:0] ny,
    output logic                      q_valid,
    input  logic                      q_pop,
    output m2bl_pkg::item_t           q_item
);
    import m2bl_pkg::*;

    item_t      buf_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    item_t      cls;
    logic       push;
    logic       row_ok, col_ok;

    assign row_ok = {1'b0, in_item.row} < nx;
    assign col_ok = {1'b0, in_item.col} < ny;

    // tag write words whose index falls outside the axes in use
    always_comb
    begin
        cls = in_item;
        case (in_item.cmd)
            CMD_WR_X:   cls.idx_ok = row_ok;
            CMD_WR_Y:   cls.idx_ok = col_ok;
            CMD_WR_MAP: cls.idx_ok = row_ok && col_ok;
            default:    cls.idx_ok = 1'b1;
        endcase
    end

    assign in_ready = count_reg != 2'd2;
    assign push     = in_valid && in_ready;
    assign q_valid  = count_reg != 2'd0;
    assign q_item   = buf_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= cls;
        end
    end
endmodule

// File: src/m2bl_back.sv
module m2bl_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    output logic                       q_pop,
    input  m2bl_pkg::item_t            q_item,
    input  logic [m2bl_pkg::CNT_W-1:0] nx,
    input  logic [m2bl_pkg::CNT_W-1:0] ny,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [15:0]                out_value,
    output logic [3:0]                 out_flags
);
    import m2bl_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_EXEC     = 11'b00000000010,
        S_SCAN     = 11'b00000000100,
        S_SCAN_END = 11'b00000001000,
        S_RD_LO    = 11'b00000010000,
        S_RD_HI    = 11'b00000100000,
        S_FRAC     = 11'b00001000000,
        S_DIV      = 11'b00010000000,
        S_GRID     = 11'b00100000000,
        S_MUL      = 11'b01000000000,
        S_DONE     = 11'b10000000000
    } state_t;

    localparam logic [FRAC_W-1:0] ONE_FRAC = FRAC_W'(1) << FRACTION_BITS;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRACTION_BITS - 1);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    item_t                        item_reg, item_next;
    logic                         axis_reg, axis_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         dv_reg, dv_next;
    logic [3:0]                   didx_reg, didx_next;
    logic [3:0]                   lo_reg, lo_next;
    logic signed [DATA_WIDTH-1:0] ax0_reg, ax0_next;
    logic signed [DATA_WIDTH-1:0] axn_reg, axn_next;
    logic signed [DATA_WIDTH-1:0] blo_reg, blo_next;
    logic signed [DATA_WIDTH-1:0] lim_reg, lim_next;
    logic                         xcl_reg, xcl_next;
    logic                         ycl_reg, ycl_next;
    logic [FRAC_W-1:0]            fx_reg, fx_next;
    logic [FRAC_W-1:0]            fy_reg, fy_next;
    logic [3:0]                   xlo_reg, xlo_next;
    logic [3:0]                   ylo_reg, ylo_next;
    logic                         bad_reg, bad_next;
    logic [FRAC_W:0]              rem_reg, rem_next;
    logic [FRAC_W-1:0]            den_reg, den_next;
    logic [FRACTION_BITS-1:0]     quo_reg, quo_next;
    logic [2:0]                   g_reg, g_next;
    logic signed [DATA_WIDTH-1:0] corner_reg [4];
    logic signed [DATA_WIDTH-1:0] corner_next [4];
    logic [2:0]                   m_reg, m_next;
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic signed [DATA_WIDTH-1:0] r0_reg, r0_next;
    logic signed [DATA_WIDTH-1:0] r1_reg, r1_next;
    logic signed [DATA_WIDTH-1:0] res_reg, res_next;
    status_t                      st_reg, st_next;
    logic [15:0]                  ov_reg, ov_next;
    logic [3:0]                   of_reg, of_next;

    logic [3:0]                   rd_addr;
    logic [GRID_AW-1:0]           g_addr;
    logic [DATA_WIDTH-1:0]        x_rdata, y_rdata, g_rdata;
    logic signed [DATA_WIDTH-1:0] ax_rd;
    logic [CNT_W-1:0]             n_cur;
    logic [3:0]                   n_m1, n_m2;
    logic signed [15:0]           q_cur;
    logic                         we_x, we_y, we_g;
    logic [GRID_AW-1:0]           w_addr;
    logic                         below, above;
    logic [3:0]                   lo_fin;
    logic signed [DATA_WIDTH:0]   num, den;
    logic [FRAC_W:0]              rem_sh;
    logic signed [DATA_WIDTH-1:0] opnd;
    logic [FRAC_W-1:0]            wgt;
    logic signed [ACC_W-1:0]      prod;
    logic signed [ACC_W-1:0]      rnd_full;
    logic signed [DATA_WIDTH-1:0] rnd;
    logic                         frac_done;
    logic [FRAC_W-1:0]            frac_val;
    logic [3:0]                   gx, gy;

    assign ax_rd = axis_reg ? $signed(y_rdata) : $signed(x_rdata);
    assign n_cur = axis_reg ? ny : nx;
    assign n_m1  = 4'(n_cur - CNT_W'(1));
    assign n_m2  = 4'(n_cur - CNT_W'(2));
    assign q_cur = axis_reg ? item_reg.qy : item_reg.qx;

    assign we_x   = (state_reg == S_EXEC) && item_reg.cmd == CMD_WR_X && item_reg.idx_ok;
    assign we_y   = (state_reg == S_EXEC) && item_reg.cmd == CMD_WR_Y && item_reg.idx_ok;
    assign we_g   = (state_reg == S_EXEC) && item_reg.cmd == CMD_WR_MAP && item_reg.idx_ok;
    assign w_addr = GRID_AW'(item_reg.row * MAX_Y_POINTS) + GRID_AW'(item_reg.col);

    assign below  = q_cur < ax0_reg;
    assign above  = q_cur >= axn_reg;
    assign lo_fin = below ? 4'd0 : (above ? n_m2 : lo_reg);

    assign num    = {lim_reg[DATA_WIDTH-1], lim_reg} - {blo_reg[DATA_WIDTH-1], blo_reg};
    assign den    = {ax_rd[DATA_WIDTH-1], ax_rd} - {blo_reg[DATA_WIDTH-1], blo_reg};
    assign rem_sh = {rem_reg[FRAC_W-1:0], 1'b0};

    always_comb
    begin
        case (state_reg)
            S_SCAN:  rd_addr = cnt_reg[3:0];
            S_RD_LO: rd_addr = lo_fin;
            S_RD_HI: rd_addr = lo_reg + 4'd1;
            default: rd_addr = 4'd0;
        endcase
    end

    // corner order: (xlo,ylo) (xlo,ylo+1) (xlo+1,ylo) (xlo+1,ylo+1)
    assign gx     = xlo_reg + {3'd0, g_reg[1]};
    assign gy     = ylo_reg + {3'd0, g_reg[0]};
    assign g_addr = GRID_AW'(gx * MAX_Y_POINTS) + GRID_AW'(gy);

    always_comb
    begin
        case (m_reg)
            3'd0:    begin opnd = corner_reg[0]; wgt = ONE_FRAC - fy_reg; end
            3'd1:    begin opnd = corner_reg[1]; wgt = fy_reg;            end
            3'd2:    begin opnd = corner_reg[2]; wgt = ONE_FRAC - fy_reg; end
            3'd3:    begin opnd = corner_reg[3]; wgt = fy_reg;            end
            3'd4:    begin opnd = r0_reg;        wgt = ONE_FRAC - fx_reg; end
            default: begin opnd = r1_reg;        wgt = fx_reg;            end
        endcase
    end

    assign prod     = ACC_W'(opnd) * ACC_W'($signed({1'b0, wgt}));
    assign rnd_full = (acc_reg + HALF) >>> FRACTION_BITS;
    assign rnd      = rnd_full[DATA_WIDTH-1:0];

    m2bl_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_X_POINTS)) u_x_ram (
        .clk   (clk),
        .we    (we_x),
        .waddr (item_reg.row),
        .wdata (item_reg.wv),
        .raddr (rd_addr),
        .rdata (x_rdata)
    );

    m2bl_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_Y_POINTS)) u_y_ram (
        .clk   (clk),
        .we    (we_y),
        .waddr (item_reg.col),
        .wdata (item_reg.wv),
        .raddr (rd_addr),
        .rdata (y_rdata)
    );

    m2bl_ram #(.WIDTH(DATA_WIDTH), .DEPTH(GRID_D)) u_grid_ram (
        .clk   (clk),
        .we    (we_g),
        .waddr (w_addr),
        .wdata (item_reg.wv),
        .raddr (g_addr),
        .rdata (g_rdata)
    );

    assign q_pop = (state_reg == S_IDLE) && q_valid;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        item_next      = item_reg;
        axis_next      = axis_reg;
        cnt_next       = cnt_reg;
        dv_next        = 1'b0;
        didx_next      = didx_reg;
        lo_next        = lo_reg;
        ax0_next       = ax0_reg;
        axn_next       = axn_reg;
        blo_next       = blo_reg;
        lim_next       = lim_reg;
        xcl_next       = xcl_reg;
        ycl_next       = ycl_reg;
        fx_next        = fx_reg;
        fy_next        = fy_reg;
        xlo_next       = xlo_reg;
        ylo_next       = ylo_reg;
        bad_next       = bad_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        quo_next       = quo_reg;
        g_next         = g_reg;
        corner_next    = corner_reg;
        m_next         = m_reg;
        acc_next       = acc_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        res_next       = res_reg;
        st_next        = st_reg;
        ov_next        = ov_reg;
        of_next        = of_reg;
        frac_done      = 1'b0;
        frac_val       = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        // scan compare runs in the cycle after its address is issued
        if (dv_reg)
        begin
            if (didx_reg == 4'd0)
                ax0_next = ax_rd;
            if (didx_reg == n_m1)
                axn_next = ax_rd;
            if (q_cur > ax_rd)
                lo_next = (didx_reg > n_m2) ? n_m2 : didx_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    item_next  = q_item;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (item_reg.cmd == CMD_LOOKUP)
                begin
                    axis_next  = 1'b0;
                    cnt_next   = '0;
                    lo_next    = 4'd0;
                    bad_next   = 1'b0;
                    state_next = S_SCAN;
                end
                else
                begin
                    res_next   = '0;
                    xcl_next   = 1'b0;
                    ycl_next   = 1'b0;
                    st_next    = item_reg.idx_ok ? ST_OK : ST_BAD_INDEX;
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                dv_next   = 1'b1;
                didx_next = cnt_reg[3:0];
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg[3:0] == n_m1)
                    state_next = S_SCAN_END;
            end
            S_SCAN_END:
            begin
                state_next = S_RD_LO;
            end
            S_RD_LO:
            begin
                lo_next  = lo_fin;
                lim_next = below ? ax0_reg : (above ? axn_reg : q_cur);
                if (axis_reg)
                    ycl_next = below || (q_cur > axn_reg);
                else
                    xcl_next = below || (q_cur > axn_reg);
                state_next = S_RD_HI;
            end
            S_RD_HI:
            begin
                blo_next   = ax_rd;
                state_next = S_FRAC;
            end
            S_FRAC:
            begin
                if (den <= 0)
                begin
                    bad_next  = 1'b1;
                    frac_done = 1'b1;
                end
                else if (num <= 0)
                    frac_done = 1'b1;
                else if (num >= den)
                begin
                    frac_done = 1'b1;
                    frac_val  = ONE_FRAC;
                end
                else
                begin
                    rem_next   = (FRAC_W + 1)'(num);
                    den_next   = FRAC_W'(den);
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // restoring division, one quotient bit a cycle
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = rem_sh - {1'b0, den_reg};
                    quo_next = {quo_reg[FRACTION_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[FRACTION_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(FRACTION_BITS - 1))
                begin
                    frac_done = 1'b1;
                    frac_val  = {1'b0, quo_next};
                end
            end
            S_GRID:
            begin
                if (g_reg != 3'd0)
                    corner_next[2'(g_reg - 3'd1)] = g_rdata;
                g_next = g_reg + 3'd1;
                if (g_reg == 3'd4)
                begin
                    if (bad_reg)
                    begin
                        res_next   = corner_reg[0];
                        st_next    = ST_ZERO_WIDTH;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        m_next     = 3'd0;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                m_next = m_reg + 3'd1;
                if (m_reg != 3'd6)
                    acc_next = m_reg[0] ? acc_reg + prod : prod;
                if (m_reg == 3'd2)
                    r0_next = rnd;
                if (m_reg == 3'd4)
                    r1_next = rnd;
                if (m_reg == 3'd6)
                begin
                    res_next   = rnd;
                    st_next    = ST_OK;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    ov_next        = res_reg;
                    of_next        = {ycl_reg, xcl_reg, st_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (frac_done)
        begin
            if (axis_reg)
            begin
                fy_next    = frac_val;
                ylo_next   = lo_reg;
                g_next     = 3'd0;
                state_next = S_GRID;
            end
            else
            begin
                fx_next    = frac_val;
                xlo_next   = lo_reg;
                axis_next  = 1'b1;
                cnt_next   = '0;
                lo_next    = 4'd0;
                state_next = S_SCAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            axis_reg      <= 1'b0;
            cnt_reg       <= '0;
            dv_reg        <= 1'b0;
            g_reg         <= 3'd0;
            m_reg         <= 3'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            axis_reg      <= axis_next;
            cnt_reg       <= cnt_next;
            dv_reg        <= dv_next;
            g_reg         <= g_next;
            m_reg         <= m_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        didx_reg   <= didx_next;
        lo_reg     <= lo_next;
        ax0_reg    <= ax0_next;
        axn_reg    <= axn_next;
        blo_reg    <= blo_next;
        lim_reg    <= lim_next;
        xcl_reg    <= xcl_next;
        ycl_reg    <= ycl_next;
        fx_reg     <= fx_next;
        fy_reg     <= fy_next;
        xlo_reg    <= xlo_next;
        ylo_reg    <= ylo_next;
        bad_reg    <= bad_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        quo_reg    <= quo_next;
        corner_reg <= corner_next;
        acc_reg    <= acc_next;
        r0_reg     <= r0_next;
        r1_reg     <= r1_next;
        res_reg    <= res_next;
        st_reg     <= st_next;
        ov_reg     <= ov_next;
        of_reg     <= of_next;
    end

    assign out_valid = out_valid_reg;
    assign out_value = ov_reg;
    assign out_flags = of_reg;
endmodule

// File: src/map_2d_bilinear_lookup.sv
// 2-D bilinear map lookup. Words on the s_ side either load an X breakpoint,
// a Y breakpoint or a map cell, or request a lookup; every word returns one
// result word. A lookup scans each axis serially through its breakpoint RAM,
// runs a restoring divider per axis when the query falls strictly inside an
// interval, reads the four corner cells and blends them on one shared
// multiplier. A two-word input queue and the output register let both sides
// stall independently. Breakpoints and cells read before being written return
// undefined data. The point counts may only be changed while no word is in
// flight.
module map_2d_bilinear_lookup (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // row_index[3:0], col_index[7:4], write_value[23:8], query_x[39:24], query_y[55:40]
    input  logic [55:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // interpolated[15:0]
    output logic [15:0] m_tdata,
    // status[1:0], x_clamped[2], y_clamped[3]
    output logic [3:0]  m_tuser,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);
    import m2bl_pkg::*;

    logic [CNT_W-1:0] x_pts_reg, y_pts_reg;
    logic [CNT_W-1:0] nx, ny;
    item_t            in_item, q_item;
    logic             q_valid, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_pts_reg <= CNT_W'(16);
            y_pts_reg <= CNT_W'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_X_POINTS: x_pts_reg <= cfg_data;
                CFG_Y_POINTS: y_pts_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign nx = used_count(x_pts_reg, CNT_W'(MAX_X_POINTS));
    assign ny = used_count(y_pts_reg, CNT_W'(MAX_Y_POINTS));

    always_comb
    begin
        in_item.cmd    = cmd_t'(s_tuser);
        in_item.idx_ok = 1'b1;
        in_item.row    = s_tdata[3:0];
        in_item.col    = s_tdata[7:4];
        in_item.wv     = s_tdata[23:8];
        in_item.qx     = s_tdata[39:24];
        in_item.qy     = s_tdata[55:40];
    end

    m2bl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .nx       (nx),
        .ny       (ny),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    m2bl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .nx        (nx),
        .ny        (ny),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (m_tdata),
        .out_flags (m_tuser)
    );
endmodule

// File: src/m2bl_checker.sv
module m2bl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [3:0]  m_tuser
);
    import m2bl_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    a_bad_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] == ST_BAD_INDEX |-> m_tdata == 16'd0 && m_tuser[3:2] == 2'b00)
        else $error("rejected write returned nonzero data");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[1:0] != 2'b11)
        else $error("unknown status code");
endmodule

bind map_2d_bilinear_lookup m2bl_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/sv/map_2d_bilinear_lookup_test.sv
module map_2d_bilinear_lookup_test;
    import m2bl_pkg::*;

    localparam int  N_PTS     = 16;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        cmd_t               cmd;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [15:0] wv;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
    } word_t;

    typedef struct {
        logic [15:0] val;
        status_t     st;
        logic        xc;
        logic        yc;
    } lookup_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // row_index[3:0], col_index[7:4], write_value[23:8], query_x[39:24], query_y[55:40]
    logic [55:0] s_tdata;
    // cmd[1:0]
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // interpolated[15:0]
    logic [15:0] m_tdata;
    // status[1:0], x_clamped[2], y_clamped[3]
    logic [3:0]  m_tuser;
    logic        cfg_we;
    logic        cfg_index;
    logic [4:0]  cfg_data;

    map_2d_bilinear_lookup DUT (.*);

    // predictor state, updated at acceptance
    longint      x_bp [N_PTS];
    longint      y_bp [N_PTS];
    longint      cells [N_PTS*N_PTS];
    logic [4:0]  x_cnt_reg = 5'd16;
    logic [4:0]  y_cnt_reg = 5'd16;

    // stimulus-side shadow of the axes, updated as words are queued
    int          gx [N_PTS];
    int          gy [N_PTS];
    int          gnx = 16;
    int          gny = 16;

    word_t       pending_words[$];
    lookup_res_t expected_res[$];
    word_t       cur_word;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_left = 0;
    int          errors = 0;
    int          n_lookups = 0, n_clamped = 0, n_zero_width = 0, n_bad_index = 0;
    longint      cycles = 0;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic int clip_count(input logic [4:0] r);
        if (r < 2) return 2;
        if (r > N_PTS) return N_PTS;
        return int'(r);
    endfunction

    function automatic longint rnd_shift(input longint v);
        return (v + 64'sd32768) >>> FRACTION_BITS;
    endfunction

    function automatic bit find_interval(input longint ax[N_PTS], input int n, input longint q,
                                         output int lo, output longint frac, output bit clamped);
        longint lim, num, den;
        clamped = 0;
        if (q < ax[0]) begin
            lo = 0; lim = ax[0]; clamped = 1;
        end else if (q >= ax[n-1]) begin
            lo = n - 2; lim = ax[n-1]; clamped = (q > ax[n-1]);
        end else begin
            lim = q; lo = 0;
            for (int i = 0; i < n; i++)
                if (q > ax[i]) lo = i;
            if (lo > n - 2) lo = n - 2;
        end
        num = lim - ax[lo];
        den = ax[lo+1] - ax[lo];
        frac = 0;
        if (den <= 0) return 0;
        if (num >= den) frac = 64'sd1 << FRACTION_BITS;
        else if (num > 0) frac = (num << FRACTION_BITS) / den;
        return 1;
    endfunction

    function automatic lookup_res_t predict_word(input word_t w);
        lookup_res_t r;
        int nx, ny, xlo, ylo;
        longint fx, fy, a, b, c, d, r0, r1, one, res;
        bit cx, cy, okx, oky;
        nx = clip_count(x_cnt_reg);
        ny = clip_count(y_cnt_reg);
        r = '{val: 16'd0, st: ST_OK, xc: 1'b0, yc: 1'b0};
        one = 64'sd1 << FRACTION_BITS;
        case (w.cmd)
            CMD_WR_X:
                if (w.row < nx) x_bp[w.row] = w.wv; else r.st = ST_BAD_INDEX;
            CMD_WR_Y:
                if (w.col < ny) y_bp[w.col] = w.wv; else r.st = ST_BAD_INDEX;
            CMD_WR_MAP:
                if (w.row < nx && w.col < ny) cells[w.row*N_PTS + w.col] = w.wv;
                else r.st = ST_BAD_INDEX;
            default: begin
                okx = find_interval(x_bp, nx, longint'(w.qx), xlo, fx, cx);
                oky = find_interval(y_bp, ny, longint'(w.qy), ylo, fy, cy);
                r.xc = cx;
                r.yc = cy;
                if (!okx || !oky) begin
                    r.st = ST_ZERO_WIDTH;
                    res = cells[xlo*N_PTS + ylo];
                end else begin
                    a = cells[xlo*N_PTS + ylo];
                    b = cells[xlo*N_PTS + ylo + 1];
                    c = cells[(xlo+1)*N_PTS + ylo];
                    d = cells[(xlo+1)*N_PTS + ylo + 1];
                    r0 = rnd_shift(a*(one - fy) + b*fy);
                    r1 = rnd_shift(c*(one - fy) + d*fy);
                    res = rnd_shift(r0*(one - fx) + r1*fx);
                end
                r.val = res[15:0];
            end
        endcase
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                lookup_res_t e;
                e = predict_word(cur_word);
                expected_res.push_back(e);
                if (cur_word.cmd == CMD_LOOKUP) begin
                    n_lookups++;
                    if (e.xc || e.yc) n_clamped++;
                    if (e.st == ST_ZERO_WIDTH) n_zero_width++;
                end else if (e.st == ST_BAD_INDEX) n_bad_index++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_word.qy, cur_word.qx, cur_word.wv, cur_word.col, cur_word.row};
                    s_tuser  <= cur_word.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_res.size() == 0) begin
                    $error("result word with nothing expected: data %h user %h", m_tdata, m_tuser);
                    errors++;
                end else begin
                    lookup_res_t e;
                    e = expected_res.pop_front();
                    if (m_tdata !== e.val) begin
                        $error("interpolated: expected %0d got %0d",
                               $signed(e.val), $signed(m_tdata));
                        errors++;
                    end
                    if (m_tuser[1:0] !== e.st) begin
                        $error("status: expected %0d got %0d", e.st, m_tuser[1:0]);
                        errors++;
                    end
                    if (m_tuser[2] !== e.xc) begin
                        $error("x_clamped: expected %0d got %0d", e.xc, m_tuser[2]);
                        errors++;
                    end
                    if (m_tuser[3] !== e.yc) begin
                        $error("y_clamped: expected %0d got %0d", e.yc, m_tuser[3]);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycles, expected_res.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic signed [15:0] sat16(input int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic int rnd16();
        return int'($signed(16'($urandom)));
    endfunction

    task automatic queue_word(input cmd_t c, input int row, input int col, input int wv,
                              input int qx = 0, input int qy = 0);
        word_t w;
        w.cmd = c; w.row = row[3:0]; w.col = col[3:0];
        w.wv = sat16(wv); w.qx = sat16(qx); w.qy = sat16(qy);
        pending_words.push_back(w);
        if (c == CMD_WR_X && row < gnx) gx[row] = w.wv;
        if (c == CMD_WR_Y && col < gny) gy[col] = w.wv;
    endtask

    // reload the active part of one axis with a sorted set, sometimes with repeats
    task automatic load_axis(input bit is_y);
        int vals[$];
        int n;
        n = is_y ? gny : gnx;
        for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(15) == 0) vals.push_back(vals[i-1]);
            else if ($urandom_range(3) == 0) vals.push_back(rnd16());
            else vals.push_back($urandom_range(4000) - 2000);
        end
        vals.sort();
        for (int i = 0; i < n; i++)
            if (is_y) queue_word(CMD_WR_Y, $urandom_range(15), i, vals[i]);
            else queue_word(CMD_WR_X, i, $urandom_range(15), vals[i]);
    endtask

    function automatic int pick_query(input bit is_y);
        int n, lo, hi;
        n  = is_y ? gny : gnx;
        lo = is_y ? gy[0] : gx[0];
        hi = is_y ? gy[n-1] : gx[n-1];
        case ($urandom_range(9))
            0: return rnd16();
            1: return is_y ? gy[$urandom_range(n-1)] : gx[$urandom_range(n-1)];
            2: return lo - int'($urandom_range(50));
            3: return hi + int'($urandom_range(50));
            default: return (lo < hi) ? lo + int'($urandom_range(hi - lo)) : lo;
        endcase
    endfunction

    task automatic queue_random(input int count);
        for (int k = 0; k < count; k++) begin
            int sel;
            sel = $urandom_range(99);
            if (sel < 3) load_axis($urandom_range(1));
            else if (sel < 25)
                queue_word(CMD_WR_MAP, $urandom_range(gnx-1), $urandom_range(gny-1), rnd16());
            else if (sel < 92)
                queue_word(CMD_LOOKUP, $urandom_range(15), $urandom_range(15), rnd16(),
                           pick_query(0), pick_query(1));
            else if (sel < 96)
                // out-of-range indexes or a stray breakpoint that may break the order
                queue_word(cmd_t'($urandom_range(2)), $urandom_range(15), $urandom_range(15),
                           rnd16());
            else
                queue_word(CMD_LOOKUP, $urandom_range(15), $urandom_range(15), rnd16(),
                           rnd16(), rnd16());
        end
    endtask

    task automatic wait_drained();
        wait (pending_words.size() == 0 && expected_res.size() == 0 && !s_tvalid);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [4:0] v);
        @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_X_POINTS) x_cnt_reg = v; else y_cnt_reg = v;
    endtask

    task automatic set_points(input logic [4:0] xr, input logic [4:0] yr);
        wait_drained();
        write_reg(CFG_X_POINTS, xr);
        write_reg(CFG_Y_POINTS, yr);
        gnx = clip_count(xr);
        gny = clip_count(yr);
    endtask

    task automatic run_phase(input int idle_s, input int stall_r, input logic [4:0] xr,
                             input logic [4:0] yr, input int count, input int hold = 0);
        set_points(xr, yr);
        send_idle_pct = idle_s;
        recv_stall_pct = stall_r;
        hold_left = hold;
        queue_random(count);
        wait_drained();
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
        foreach (x_bp[i]) begin x_bp[i] = 0; y_bp[i] = 0; end
        foreach (cells[i]) cells[i] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // fill every store at full size so no unwritten entry is ever read
        load_axis(0);
        load_axis(1);
        for (int r = 0; r < N_PTS; r++)
            for (int c = 0; c < N_PTS; c++)
                queue_word(CMD_WR_MAP, r, c, rnd16());
        queue_word(CMD_WR_MAP, 0, 0, 32767);
        queue_word(CMD_WR_MAP, 0, 1, -32768);
        queue_word(CMD_WR_MAP, 1, 0, -32768);
        queue_word(CMD_WR_MAP, 1, 1, 32767);
        queue_word(CMD_WR_MAP, 15, 15, -32768);

        // directed: extremes, exact breakpoints, mid points, flat interval
        queue_word(CMD_LOOKUP, 15, 15, -1, -32768, -32768);
        queue_word(CMD_LOOKUP, 0, 0, 0, 32767, 32767);
        queue_word(CMD_LOOKUP, 0, 0, 0, -32768, 32767);
        queue_word(CMD_LOOKUP, 0, 0, 0, gx[0], gy[0]);
        queue_word(CMD_LOOKUP, 0, 0, 0, gx[15], gy[15]);
        queue_word(CMD_LOOKUP, 0, 0, 0, gx[7], gy[3]);
        queue_word(CMD_LOOKUP, 0, 0, 0, (gx[0] + gx[1]) / 2, (gy[0] + gy[1]) / 2);
        queue_word(CMD_LOOKUP, 0, 0, 0, gx[15] + 1, gy[0] - 1);
        queue_word(CMD_WR_X, 1, 0, gx[0]);
        queue_word(CMD_LOOKUP, 0, 0, 0, -32768, gy[5]);
        queue_word(CMD_WR_Y, 0, 3, gy[2] - 1);
        queue_word(CMD_LOOKUP, 0, 0, 0, gx[9], gy[2]);
        load_axis(0);
        load_axis(1);
        wait_drained();

        // smallest sizes: out-of-range writes for every write command
        set_points(5'd2, 5'd2);
        queue_word(CMD_WR_X, 2, 0, 123);
        queue_word(CMD_WR_Y, 0, 15, 123);
        queue_word(CMD_WR_MAP, 15, 0, 123);
        queue_word(CMD_WR_MAP, 0, 2, 123);
        queue_word(CMD_WR_MAP, 1, 1, 4321);
        queue_word(CMD_LOOKUP, 0, 0, 0, 32767, 32767);
        wait_drained();

        run_phase(0,  0,  5'd16, 5'd16, 150);
        run_phase(60, 0,  5'd0,  5'd31, 150);
        run_phase(0,  60, 5'd1,  5'd2,  150, 600);
        run_phase(38, 38, 5'd7,  5'd12, 150);
        run_phase(0,  0,  5'd17, 5'd3,  120);
        run_phase(38, 38, 5'd2,  5'd16, 120);
        run_phase(0,  60, 5'd16, 5'd16, 120);

        wait (expected_res.size() == 0);
        repeat (200) @(posedge clk);
        $display("covered %0d lookups (%0d clamped, %0d flat or descending intervals)",
                 n_lookups, n_clamped, n_zero_width);
        $display("and %0d out-of-range writes over point counts from 2 to 16", n_bad_index);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
